FILE: hw/rtl/sas_pkg.sv
package sas_pkg;

  localparam int unsigned PROB_W     = 16;
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned PERIOD_W   = 8;
  localparam int unsigned FRAME_W    = 24;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SPK_ID_W   = 2;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 24;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ONSET_LEVEL     = 4'd0,
    REG_OFFSET_LEVEL    = 4'd1,
    REG_PAD_BEFORE_MS   = 4'd2,
    REG_PAD_AFTER_MS    = 4'd3,
    REG_MIN_GAP_MS      = 4'd4,
    REG_MIN_LENGTH_MS   = 4'd5,
    REG_FRAME_PERIOD_MS = 4'd6,
    REG_FRAME_TOTAL     = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [LEVEL_W-1:0]  onset_level;
    logic [LEVEL_W-1:0]  offset_level;
    logic [MS_W-1:0]     pad_before_ms;
    logic [MS_W-1:0]     pad_after_ms;
    logic [MS_W-1:0]     min_gap_ms;
    logic [MS_W-1:0]     min_length_ms;
    logic [PERIOD_W-1:0] frame_period_ms;
    logic [FRAME_W-1:0]  frame_total;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    onset_level:     16'd32768,
    offset_level:    16'd32768,
    pad_before_ms:   16'd0,
    pad_after_ms:    16'd0,
    min_gap_ms:      16'd0,
    min_length_ms:   16'd0,
    frame_period_ms: 8'd80,
    frame_total:     24'hFFFFFF
  };

  typedef struct packed {
    logic [PROB_W-1:0] prob_spk0;
    logic [PROB_W-1:0] prob_spk1;
    logic [PROB_W-1:0] prob_spk2;
    logic [PROB_W-1:0] prob_spk3;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0]   seg_begin_ms;
    logic [TIME_W-1:0]   seg_finish_ms;
    logic [SPK_ID_W-1:0] speaker_id;
    logic                last_of_run;
  } out_item_t;

  // Per-frame timing shared by all lanes
  typedef struct packed {
    logic               last;
    logic [FRAME_W-1:0] frame;
    logic [TIME_W-1:0]  start_ms;
    logic [TIME_W-1:0]  total_ms;
    logic [TIME_W-1:0]  end_close_ms;
    logic [TIME_W-1:0]  begin_ms;
  } frame_t;

  typedef struct packed {
    logic [TIME_W-1:0] begin_ms;
    logic [TIME_W-1:0] finish_ms;
  } seg_t;

  // Up to two finished segments from one lane per frame, in emission order
  typedef struct packed {
    logic first_v;
    seg_t first_seg;
    logic second_v;
    seg_t second_seg;
  } lane_res_t;

endpackage

FILE: hw/rtl/sas_front.sv
module sas_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sas_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sas_pkg::in_item_t in_item_i,
  input  logic              adv_i,
  output logic              fire_o,
  output sas_pkg::in_item_t item_o,
  output sas_pkg::frame_t   frame_o
);
  import sas_pkg::*;

  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  in_item_t s1_item_q, s2_item_q, s3_item_q, s4_item_q;
  logic [FRAME_W-1:0] s2_frame_q, s3_frame_q;
  logic s2_last_q, s3_last_q;
  logic [TIME_W-1:0] s3_start_q, s3_total_q;
  frame_t s4_frame_q;
  logic [FRAME_W-1:0] fcnt_q;

  logic mv1, mv2, mv3, mv4, acc;
  logic cnt_last;
  logic [TIME_W-1:0] start_d, total_d, begin_d, end_d;
  logic [TIME_W:0] end_sum;

  // Stage moves: a stage loads when it is empty or passes its item on
  always_comb begin
    mv4        = s4_v_q && adv_i;
    mv3        = s3_v_q && (!s4_v_q || mv4);
    mv2        = s2_v_q && (!s3_v_q || mv3);
    mv1        = s1_v_q && (!s2_v_q || mv2);
    acc        = in_valid_i && (!s1_v_q || mv1);
    in_stall_o = s1_v_q && !mv1;
    fire_o     = mv4;
    item_o     = s4_item_q;
    frame_o    = s4_frame_q;
  end

  // Frame timing arithmetic, one step per stage
  always_comb begin
    cnt_last = fcnt_q == (cfg_i.frame_total - FRAME_W'(1));
    start_d  = {8'd0, s2_frame_q} * {24'd0, cfg_i.frame_period_ms};
    total_d  = {8'd0, cfg_i.frame_total} * {24'd0, cfg_i.frame_period_ms};
    end_sum  = {1'b0, s3_start_q} + {17'd0, cfg_i.pad_after_ms};
    end_d    = (end_sum > {1'b0, s3_total_q}) ? s3_total_q : end_sum[TIME_W-1:0];
    begin_d  = (s3_start_q >= {16'd0, cfg_i.pad_before_ms}) ?
               (s3_start_q - {16'd0, cfg_i.pad_before_ms}) : '0;
  end

  // Hold valid flags and the frame counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      fcnt_q <= '0;
    end else begin
      if (acc) s1_v_q <= 1'b1;
      else if (mv1) s1_v_q <= 1'b0;
      if (mv1) s2_v_q <= 1'b1;
      else if (mv2) s2_v_q <= 1'b0;
      if (mv2) s3_v_q <= 1'b1;
      else if (mv3) s3_v_q <= 1'b0;
      if (mv3) s4_v_q <= 1'b1;
      else if (mv4) s4_v_q <= 1'b0;
      if (mv1) fcnt_q <= cnt_last ? '0 : fcnt_q + FRAME_W'(1);
    end
  end

  // Advance the item payload through the stages
  always_ff @(posedge clk_i) begin
    if (acc) s1_item_q <= in_item_i;
    if (mv1) begin
      s2_item_q  <= s1_item_q;
      s2_frame_q <= fcnt_q;
      s2_last_q  <= cnt_last;
    end
    if (mv2) begin
      s3_item_q  <= s2_item_q;
      s3_frame_q <= s2_frame_q;
      s3_last_q  <= s2_last_q;
      s3_start_q <= start_d;
      s3_total_q <= total_d;
    end
    if (mv3) begin
      s4_item_q               <= s3_item_q;
      s4_frame_q.last         <= s3_last_q;
      s4_frame_q.frame        <= s3_frame_q;
      s4_frame_q.start_ms     <= s3_start_q;
      s4_frame_q.total_ms     <= s3_total_q;
      s4_frame_q.end_close_ms <= end_d;
      s4_frame_q.begin_ms     <= begin_d;
    end
  end

endmodule

FILE: hw/rtl/sas_lane.sv
module sas_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sas_pkg::cfg_t                 cfg_i,
  input  logic [sas_pkg::PROB_W-1:0]    prob_i,
  input  sas_pkg::frame_t               frame_i,
  input  logic                          fire_i,
  output sas_pkg::lane_res_t            res_o
);
  import sas_pkg::*;

  // True when hi - lo, taken as signed, is at least lim
  function automatic logic at_least(input logic [TIME_W-1:0] lo,
                                    input logic [TIME_W-1:0] hi,
                                    input logic [MS_W-1:0] lim);
    logic signed [TIME_W:0] diff;
    diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
    return diff >= $signed({17'd0, lim});
  endfunction

  logic act_q, pv_q;
  logic [TIME_W-1:0] pb_q, pf_q;
  logic [FRAME_W-1:0] os_q;
  logic [TIME_W-1:0] oft_q, ob_q;

  logic opening, closing_lvl, act_a, closing, merge, end_later;
  logic ok_old, ok_ext, ok_new, ok1, pv1;
  logic [TIME_W-1:0] end_sel, begin_sel, pb1, pf1;

  // Hysteresis, close, gap merge and length checks for one frame
  always_comb begin
    opening     = !act_q && (prob_i > cfg_i.onset_level);
    closing_lvl = act_q && (prob_i < cfg_i.offset_level);
    act_a       = opening || (act_q && !closing_lvl);
    closing     = closing_lvl || (frame_i.last && act_a);
    end_sel     = closing_lvl ? frame_i.end_close_ms : frame_i.total_ms;
    begin_sel   = opening ? frame_i.begin_ms : ob_q;
    merge       = pv_q && !at_least(pf_q, begin_sel, cfg_i.min_gap_ms);
    end_later   = end_sel > pf_q;
    ok_old      = at_least(pb_q, pf_q, cfg_i.min_length_ms);
    ok_ext      = at_least(pb_q, end_sel, cfg_i.min_length_ms);
    ok_new      = at_least(begin_sel, end_sel, cfg_i.min_length_ms);

    if (!closing) begin
      pv1 = pv_q;
      pb1 = pb_q;
      pf1 = pf_q;
      ok1 = ok_old;
    end else if (merge) begin
      pv1 = 1'b1;
      pb1 = pb_q;
      pf1 = end_later ? end_sel : pf_q;
      ok1 = end_later ? ok_ext : ok_old;
    end else begin
      pv1 = 1'b1;
      pb1 = begin_sel;
      pf1 = end_sel;
      ok1 = ok_new;
    end

    res_o.first_v              = closing && !merge && pv_q && ok_old;
    res_o.first_seg.begin_ms   = pb_q;
    res_o.first_seg.finish_ms  = pf_q;
    res_o.second_v             = frame_i.last && pv1 && ok1;
    res_o.second_seg.begin_ms  = pb1;
    res_o.second_seg.finish_ms = pf1;
  end

  // Update activity and pending flags; the last frame clears them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      pv_q  <= 1'b0;
    end else if (fire_i) begin
      act_q <= !frame_i.last && act_a;
      pv_q  <= !frame_i.last && pv1;
    end
  end

  // Hold the pending segment; keep the open start time tracking the registers
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      pb_q <= pb1;
      pf_q <= pf1;
    end
    if (fire_i && opening) begin
      os_q  <= frame_i.frame;
      oft_q <= frame_i.start_ms;
      ob_q  <= frame_i.begin_ms;
    end else begin
      oft_q <= {8'd0, os_q} * {24'd0, cfg_i.frame_period_ms};
      ob_q  <= (oft_q >= {16'd0, cfg_i.pad_before_ms}) ?
               (oft_q - {16'd0, cfg_i.pad_before_ms}) : '0;
    end
  end

endmodule

FILE: hw/rtl/sas_merge.sv
module sas_merge #(
  parameter int unsigned SPEAKERS = 4
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push_i,
  input  sas_pkg::lane_res_t [SPEAKERS-1:0]     res_i,
  output logic                                  ready_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output sas_pkg::out_item_t                    out_item_o
);
  import sas_pkg::*;

  localparam int unsigned SLOTS = 2 * SPEAKERS;

  logic rec_v_q;
  logic [SLOTS-1:0] rec_mask_q, wrk_mask_q;
  seg_t [SLOTS-1:0] rec_seg_q, wrk_seg_q;
  logic out_v_q;
  out_item_t out_item_q;

  logic [SLOTS-1:0] in_mask, low, rest;
  seg_t [SLOTS-1:0] in_seg;
  seg_t sel_seg;
  logic [SPK_ID_W-1:0] sel_spk;
  logic out_ready, pick, wrk_free, rec_move, push_any;

  // Gather lane results into slots, speaker order, first emission first
  always_comb begin
    for (int s = 0; s < SPEAKERS; s++) begin
      in_mask[2*s]   = res_i[s].first_v;
      in_mask[2*s+1] = res_i[s].second_v;
      in_seg[2*s]    = res_i[s].first_seg;
      in_seg[2*s+1]  = res_i[s].second_seg;
    end
  end

  // Pick the lowest pending slot of the working record
  always_comb begin
    out_ready = !out_v_q || !out_stall_i;
    low       = wrk_mask_q & (~wrk_mask_q + SLOTS'(1));
    rest      = wrk_mask_q & ~low;
    pick      = out_ready && (wrk_mask_q != '0);
    wrk_free  = (wrk_mask_q == '0) || (pick && (rest == '0));
    rec_move  = rec_v_q && wrk_free;
    ready_o   = !rec_v_q || rec_move;
    push_any  = push_i && (in_mask != '0);
    sel_seg   = '0;
    sel_spk   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (low[i]) begin
        sel_seg = wrk_seg_q[i];
        sel_spk = SPK_ID_W'(i >> 1);
      end
    end
    out_valid_o = out_v_q;
    out_item_o  = out_item_q;
  end

  // Hold record, working mask and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_v_q    <= 1'b0;
      wrk_mask_q <= '0;
      out_v_q    <= 1'b0;
    end else begin
      if (push_any) rec_v_q <= 1'b1;
      else if (rec_move) rec_v_q <= 1'b0;
      if (rec_move) wrk_mask_q <= rec_mask_q;
      else if (pick) wrk_mask_q <= rest;
      if (out_ready) out_v_q <= pick;
    end
  end

  // Move segment data along record, working set and output register
  always_ff @(posedge clk_i) begin
    if (push_any) begin
      rec_mask_q <= in_mask;
      rec_seg_q  <= in_seg;
    end
    if (rec_move) wrk_seg_q <= rec_seg_q;
    if (pick) begin
      out_item_q.seg_begin_ms  <= sel_seg.begin_ms;
      out_item_q.seg_finish_ms <= sel_seg.finish_ms;
      out_item_q.speaker_id    <= sel_spk;
      out_item_q.last_of_run   <= rest == '0;
    end
  end

endmodule

FILE: hw/rtl/speaker_activity_segmenter_core.sv
// Lanes update state once per frame. A frame's first segment leaves after the
// front stages s1 to s4, the lanes, the merge record, working set and output
// register. Throughput: one frame per cycle until a frame with segments waits
// behind one still draining; segments leave one per cycle unless out is stalled.
// Reset clears all speaker state and the frame counter and loads the register
// defaults; no clearing pass, the block takes items right after reset.
module speaker_activity_segmenter_core #(
  parameter int unsigned SPEAKERS = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  sas_pkg::in_item_t                in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output sas_pkg::out_item_t               out_item_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sas_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sas_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import sas_pkg::*;

  cfg_t cfg_q;
  logic fire, adv;
  in_item_t item;
  frame_t frame;
  lane_res_t [SPEAKERS-1:0] lane_res;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ONSET_LEVEL:     cfg_q.onset_level     <= cfg_data_i[LEVEL_W-1:0];
        REG_OFFSET_LEVEL:    cfg_q.offset_level    <= cfg_data_i[LEVEL_W-1:0];
        REG_PAD_BEFORE_MS:   cfg_q.pad_before_ms   <= cfg_data_i[MS_W-1:0];
        REG_PAD_AFTER_MS:    cfg_q.pad_after_ms    <= cfg_data_i[MS_W-1:0];
        REG_MIN_GAP_MS:      cfg_q.min_gap_ms      <= cfg_data_i[MS_W-1:0];
        REG_MIN_LENGTH_MS:   cfg_q.min_length_ms   <= cfg_data_i[MS_W-1:0];
        REG_FRAME_PERIOD_MS: cfg_q.frame_period_ms <= cfg_data_i[PERIOD_W-1:0];
        REG_FRAME_TOTAL:     cfg_q.frame_total     <= cfg_data_i[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  sas_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .adv_i      (adv),
    .fire_o     (fire),
    .item_o     (item),
    .frame_o    (frame)
  );

  // One lane per speaker; speakers past the input fields see zero
  for (genvar s = 0; s < SPEAKERS; s++) begin : g_lane
    logic [PROB_W-1:0] prob;

    always_comb begin
      case (s)
        0:       prob = item.prob_spk0;
        1:       prob = item.prob_spk1;
        2:       prob = item.prob_spk2;
        3:       prob = item.prob_spk3;
        default: prob = '0;
      endcase
    end

    sas_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cfg_i   (cfg_q),
      .prob_i  (prob),
      .frame_i (frame),
      .fire_i  (fire),
      .res_o   (lane_res[s])
    );
  end

  sas_merge #(
    .SPEAKERS (SPEAKERS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .res_i       (lane_res),
    .ready_o     (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: verif/speaker_activity_segmenter_core_test.sv
module speaker_activity_segmenter_core_test;
  import sas_pkg::*;

  localparam int SPK            = 4;
  localparam int BLOCKS         = 9;
  localparam int BLOCK_ITEMS    = 28;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 4000;

  // One row of the directed plan: a register write or a frame
  typedef struct {
    bit                    is_reg;
    cfg_reg_e              reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    in_item_t              frame;
    bit                    typed;
    int                    typed_n;
    out_item_t             typed_seg;
  } step_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_item_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_item_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Predictor copy of the registers and the speaker tracks
  cfg_t               settings = CFG_RESET;
  logic [FRAME_W-1:0] seg_frame = '0;
  bit                 spk_on [SPK];
  logic [FRAME_W-1:0] spk_open_frame [SPK] = '{default: '0};
  bit                 spk_held [SPK];
  longint             held_begin [SPK];
  longint             held_finish [SPK];

  out_item_t frame_segs[$];
  out_item_t awaited_segments[$];
  bit        talking [SPK];
  int        send_gap_pct = 0;
  int        recv_gap_pct = 0;
  int        fault_count  = 0;
  int        quiet_cycles = 0;

  speaker_activity_segmenter_core #(.SPEAKERS(SPK)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Emit a speaker's held segment if it is long enough, and drop it
  function automatic void release_held(int s);
    out_item_t seg;
    if (!spk_held[s]) return;
    spk_held[s] = 1'b0;
    if (held_finish[s] - held_begin[s] < longint'(settings.min_length_ms)) return;
    seg.seg_begin_ms  = held_begin[s][TIME_W-1:0];
    seg.seg_finish_ms = held_finish[s][TIME_W-1:0];
    seg.speaker_id    = SPK_ID_W'(s);
    seg.last_of_run   = 1'b0;
    frame_segs = {frame_segs, seg};
  endfunction

  // Pad the start of a closing segment, then merge it or hold it
  function automatic void close_span(int s, longint end_ms);
    longint begin_ms;
    begin_ms = longint'(spk_open_frame[s]) * longint'(settings.frame_period_ms)
               - longint'(settings.pad_before_ms);
    if (begin_ms < 0) begin_ms = 0;
    spk_on[s] = 1'b0;
    if (spk_held[s] && begin_ms - held_finish[s] < longint'(settings.min_gap_ms)) begin
      if (end_ms > held_finish[s]) held_finish[s] = end_ms;
      return;
    end
    release_held(s);
    spk_held[s]    = 1'b1;
    held_begin[s]  = begin_ms;
    held_finish[s] = end_ms;
  endfunction

  // Advance the speaker tracks by one frame; leave its segments in frame_segs
  function automatic void segment_frame(input in_item_t fr);
    logic [PROB_W-1:0]  p [SPK];
    logic [FRAME_W-1:0] f;
    logic [FRAME_W-1:0] last_frame;
    bit                 last;
    longint             total;
    longint             end_ms;
    p = '{fr.prob_spk0, fr.prob_spk1, fr.prob_spk2, fr.prob_spk3};
    frame_segs.delete();
    f          = seg_frame;
    last_frame = settings.frame_total - 24'd1;
    last       = (f == last_frame);
    total      = longint'(settings.frame_total) * longint'(settings.frame_period_ms);
    for (int s = 0; s < SPK; s++) begin
      if (!spk_on[s] && p[s] > settings.onset_level) begin
        spk_on[s]         = 1'b1;
        spk_open_frame[s] = f;
      end else if (spk_on[s] && p[s] < settings.offset_level) begin
        end_ms = longint'(f) * longint'(settings.frame_period_ms)
                 + longint'(settings.pad_after_ms);
        if (end_ms > total) end_ms = total;
        close_span(s, end_ms);
      end
      if (last) begin
        if (spk_on[s]) close_span(s, total);
        release_held(s);
      end
    end
    // Clear every track after the last frame of the run
    if (last) begin
      seg_frame = '0;
      for (int s = 0; s < SPK; s++) begin
        spk_on[s]         = 1'b0;
        spk_open_frame[s] = '0;
        spk_held[s]       = 1'b0;
        held_begin[s]     = 0;
        held_finish[s]    = 0;
      end
    end else begin
      seg_frame = f + 24'd1;
    end
    if (frame_segs.size() != 0) frame_segs[frame_segs.size()-1].last_of_run = 1'b1;
  endfunction

  // Random frame: mostly speech runs around the thresholds, some noise
  function automatic in_item_t draw_frame();
    logic [PROB_W-1:0] p [SPK];
    logic [PROB_W-1:0] edges [6];
    int                pick;
    edges = '{settings.onset_level, settings.offset_level, settings.onset_level + 16'd1,
              settings.offset_level - 16'd1, 16'h0000, 16'hFFFF};
    for (int s = 0; s < SPK; s++) begin
      if ($urandom_range(3, 0) == 0) talking[s] = !talking[s];
      pick = $urandom_range(19, 0);
      if (pick == 0)
        p[s] = PROB_W'($urandom);
      else if (pick == 1)
        p[s] = edges[$urandom_range(5, 0)];
      else if (talking[s])
        p[s] = (settings.onset_level == 16'hFFFF) ? 16'hFFFF :
               PROB_W'($urandom_range(65535, settings.onset_level + 1));
      else
        p[s] = (settings.offset_level == 16'h0000) ? 16'h0000 :
               PROB_W'($urandom_range(settings.offset_level - 1, 0));
    end
    return '{p[0], p[1], p[2], p[3]};
  endfunction

  function automatic step_t frame_step(input logic [PROB_W-1:0] a, b, c, d);
    step_t st;
    st.is_reg    = 1'b0;
    st.reg_idx   = REG_ONSET_LEVEL;
    st.reg_val   = '0;
    st.frame     = '{a, b, c, d};
    st.typed     = 1'b0;
    st.typed_n   = 0;
    st.typed_seg = '0;
    return st;
  endfunction

  function automatic step_t quiet_step(input logic [PROB_W-1:0] a, b, c, d);
    step_t st;
    st       = frame_step(a, b, c, d);
    st.typed = 1'b1;
    return st;
  endfunction

  function automatic step_t reg_step(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] v);
    step_t st;
    st         = frame_step(16'h0, 16'h0, 16'h0, 16'h0);
    st.is_reg  = 1'b1;
    st.reg_idx = idx;
    st.reg_val = v;
    return st;
  endfunction

  // Write one register; leave valid high for the caller to drop
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      REG_ONSET_LEVEL:     settings.onset_level     = val[LEVEL_W-1:0];
      REG_OFFSET_LEVEL:    settings.offset_level    = val[LEVEL_W-1:0];
      REG_PAD_BEFORE_MS:   settings.pad_before_ms   = val[MS_W-1:0];
      REG_PAD_AFTER_MS:    settings.pad_after_ms    = val[MS_W-1:0];
      REG_MIN_GAP_MS:      settings.min_gap_ms      = val[MS_W-1:0];
      REG_MIN_LENGTH_MS:   settings.min_length_ms   = val[MS_W-1:0];
      REG_FRAME_PERIOD_MS: settings.frame_period_ms = val[PERIOD_W-1:0];
      REG_FRAME_TOTAL:     settings.frame_total     = val[FRAME_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Offer one frame, hold it until taken, then queue its segments
  task automatic send_frame(input in_item_t fr, input bit typed = 1'b0,
                            input int typed_n = 0, input out_item_t typed_seg = '0);
    while ($urandom_range(99, 0) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= fr;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    segment_frame(fr);
    if (!typed)
      awaited_segments = {awaited_segments, frame_segs};
    else if (typed_n != 0)
      awaited_segments = {awaited_segments, typed_seg};
    @(negedge clk_i);
  endtask

  // Stop sending and wait for every awaited segment, then a tail
  task automatic settle(input int tail);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (awaited_segments.size() != 0);
    repeat (tail) @(negedge clk_i);
  endtask

  // Receiver back-pressure
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99, 0) < recv_gap_pct);
  end

  // Compare each taken segment with the oldest awaited one
  always @(posedge clk_i) begin : seg_check
    out_item_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (awaited_segments.size() == 0) begin
        fault_count++;
        $display("%0t: segment mismatch: expected none, got begin %0d finish %0d spk %0d last %0b",
                 $time, out_item_o.seg_begin_ms, out_item_o.seg_finish_ms,
                 out_item_o.speaker_id, out_item_o.last_of_run);
      end else begin
        want = awaited_segments.pop_front();
        if (out_item_o.seg_begin_ms !== want.seg_begin_ms ||
            out_item_o.seg_finish_ms !== want.seg_finish_ms ||
            out_item_o.speaker_id !== want.speaker_id ||
            out_item_o.last_of_run !== want.last_of_run) begin
          fault_count++;
          $display({"%0t: segment mismatch: expected begin %0d finish %0d spk %0d last %0b,",
                    " got begin %0d finish %0d spk %0d last %0b"},
                   $time, want.seg_begin_ms, want.seg_finish_ms, want.speaker_id,
                   want.last_of_run, out_item_o.seg_begin_ms, out_item_o.seg_finish_ms,
                   out_item_o.speaker_id, out_item_o.last_of_run);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves on any port for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    step_t plan[$];
    step_t st;
    cfg_t  draw;
    int    r;
    bit    writing;

    in_valid_i   = 1'b0;
    in_item_i    = '0;
    out_stall_i  = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    rst_ni       = 1'b0;
    send_gap_pct = 32;
    recv_gap_pct = 45;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Defaults after reset: short runs for three speakers
    plan = {plan, quiet_step(16'h0000, 16'h0000, 16'h0000, 16'h0000)};
    plan = {plan, quiet_step(16'hFFFF, 16'h8001, 16'h8000, 16'h0000)};
    plan = {plan, quiet_step(16'h0000, 16'h8000, 16'hFFFF, 16'h0000)};
    plan = {plan, quiet_step(16'hFFFF, 16'h0000, 16'h0000, 16'h0000)};
    st           = frame_step(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    st.typed     = 1'b1;
    st.typed_n   = 1;
    st.typed_seg = '{32'd80, 32'd160, 2'd0, 1'b1};
    plan = {plan, st};
    // Top onset: nothing can switch on
    plan = {plan, reg_step(REG_ONSET_LEVEL, 24'd65535)};
    plan = {plan, quiet_step(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF)};
    // Zero thresholds, then widest offset and pads: negative gaps merge
    plan = {plan, reg_step(REG_ONSET_LEVEL, 24'd0)};
    plan = {plan, reg_step(REG_OFFSET_LEVEL, 24'd0)};
    plan = {plan, frame_step(16'h0001, 16'h0000, 16'hFFFF, 16'h0000)};
    plan = {plan, reg_step(REG_OFFSET_LEVEL, 24'd65535)};
    plan = {plan, reg_step(REG_PAD_BEFORE_MS, 24'd65535)};
    plan = {plan, reg_step(REG_PAD_AFTER_MS, 24'd65535)};
    plan = {plan, frame_step(16'h0000, 16'hFFFF, 16'hFFFE, 16'h0000)};
    // Longest gap, length and period, and a run that ends two frames on
    plan = {plan, reg_step(REG_MIN_GAP_MS, 24'd65535)};
    plan = {plan, reg_step(REG_MIN_LENGTH_MS, 24'd65535)};
    plan = {plan, reg_step(REG_FRAME_PERIOD_MS, 24'd255)};
    plan = {plan, reg_step(REG_FRAME_TOTAL, 24'd10)};
    plan = {plan, frame_step(16'h0000, 16'h0000, 16'h0000, 16'h0000)};
    plan = {plan, frame_step(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF)};
    // Zero frame period: every time collapses to zero, short run flushes
    plan = {plan, reg_step(REG_MIN_LENGTH_MS, 24'd0)};
    plan = {plan, reg_step(REG_MIN_GAP_MS, 24'd0)};
    plan = {plan, reg_step(REG_PAD_BEFORE_MS, 24'd0)};
    plan = {plan, reg_step(REG_PAD_AFTER_MS, 24'd0)};
    plan = {plan, reg_step(REG_ONSET_LEVEL, 24'd32768)};
    plan = {plan, reg_step(REG_OFFSET_LEVEL, 24'd32768)};
    plan = {plan, reg_step(REG_FRAME_PERIOD_MS, 24'd0)};
    plan = {plan, reg_step(REG_FRAME_TOTAL, 24'd3)};
    plan = {plan, frame_step(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000)};
    plan = {plan, frame_step(16'h0000, 16'h0000, 16'hFFFF, 16'h0000)};
    plan = {plan, frame_step(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF)};
    // Zero frame total: ends clamp to zero, so later segments turn inverted
    plan = {plan, reg_step(REG_FRAME_PERIOD_MS, 24'd200)};
    plan = {plan, reg_step(REG_FRAME_TOTAL, 24'd0)};
    plan = {plan, frame_step(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF)};
    plan = {plan, frame_step(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF)};
    plan = {plan, frame_step(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000)};
    plan = {plan, frame_step(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF)};
    plan = {plan, frame_step(16'hFFFF, 16'h0000, 16'h0000, 16'h0000)};
    plan = {plan, frame_step(16'h0000, 16'h0000, 16'h0000, 16'h0000)};

    // Walk the plan; drain before the first write of each group
    writing = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (!writing) settle(SETTLE_CYCLES);
        writing = 1'b1;
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        if (writing) cfg_valid_i <= 1'b0;
        writing = 1'b0;
        send_frame(plan[i].frame, plan[i].typed, plan[i].typed_n, plan[i].typed_seg);
      end
    end

    for (int b = 0; b < BLOCKS; b++) begin
      send_gap_pct = (b < 3) ? 32 : (b < 6) ? 45 : 0;
      recv_gap_pct = (b < 3) ? 45 : (b < 6) ? 32 : 0;

      // Close the current run so that each setting starts from frame zero
      settle(SETTLE_CYCLES);
      write_reg(REG_FRAME_TOTAL, seg_frame + 24'd1);
      cfg_valid_i <= 1'b0;
      send_frame(draw_frame());

      // Draw the next setting: minima, maxima or a random mid-range one
      case (b)
        1: draw = '{onset_level: 16'd0, offset_level: 16'd0, pad_before_ms: 16'd0,
                    pad_after_ms: 16'd0, min_gap_ms: 16'd0, min_length_ms: 16'd0,
                    frame_period_ms: 8'd1, frame_total: 24'd1};
        4: draw = '{onset_level: 16'hFFFE, offset_level: 16'hFFFF, pad_before_ms: 16'hFFFF,
                    pad_after_ms: 16'hFFFF, min_gap_ms: 16'hFFFF,
                    min_length_ms: MS_W'($urandom_range(600, 0)),
                    frame_period_ms: 8'd255, frame_total: 24'hFFFFFF};
        default: begin
          draw.onset_level     = LEVEL_W'($urandom_range(62000, 3000));
          draw.offset_level    = ($urandom_range(7, 0) == 0) ? LEVEL_W'($urandom) :
                                 draw.onset_level - LEVEL_W'($urandom_range(2999, 0));
          draw.frame_period_ms = PERIOD_W'($urandom_range(255, 1));
          draw.pad_before_ms   = MS_W'($urandom_range(3 * draw.frame_period_ms, 0));
          draw.pad_after_ms    = MS_W'($urandom_range(3 * draw.frame_period_ms, 0));
          draw.min_gap_ms      = MS_W'($urandom_range(4 * draw.frame_period_ms, 0));
          draw.min_length_ms   = MS_W'($urandom_range(4 * draw.frame_period_ms, 0));
          r = $urandom_range(9, 0);
          draw.frame_total     = (r == 0) ? 24'hFFFFFF : (r == 1) ? 24'd0 :
                                 FRAME_W'($urandom_range(40, 2));
        end
      endcase
      settle(SETTLE_CYCLES);
      write_reg(REG_ONSET_LEVEL, CFG_DATA_W'(draw.onset_level));
      write_reg(REG_OFFSET_LEVEL, CFG_DATA_W'(draw.offset_level));
      write_reg(REG_PAD_BEFORE_MS, CFG_DATA_W'(draw.pad_before_ms));
      write_reg(REG_PAD_AFTER_MS, CFG_DATA_W'(draw.pad_after_ms));
      write_reg(REG_MIN_GAP_MS, CFG_DATA_W'(draw.min_gap_ms));
      write_reg(REG_MIN_LENGTH_MS, CFG_DATA_W'(draw.min_length_ms));
      write_reg(REG_FRAME_PERIOD_MS, CFG_DATA_W'(draw.frame_period_ms));
      write_reg(REG_FRAME_TOTAL, draw.frame_total);
      cfg_valid_i <= 1'b0;

      for (int k = 0; k < BLOCK_ITEMS; k++) begin
        // Hold off once mid-block until the output side has caught up
        if (b == 2 && k == BLOCK_ITEMS / 2) settle(0);
        send_frame(draw_frame());
      end
    end

    settle(SETTLE_CYCLES);
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: speaker_activity_segmenter_core.f
hw/rtl/sas_pkg.sv
hw/rtl/sas_front.sv
hw/rtl/sas_lane.sv
hw/rtl/sas_merge.sv
hw/rtl/speaker_activity_segmenter_core.sv
verif/speaker_activity_segmenter_core_test.sv
